### rtl/max_weight_increasing_subsequence_macros.svh
// assertion macros shared by the subsequence engine files
// bodies expect clk and arst_n in the including module
`ifndef MAX_WEIGHT_INCREASING_SUBSEQUENCE_MACROS_SVH
`define MAX_WEIGHT_INCREASING_SUBSEQUENCE_MACROS_SVH
`ifndef SYNTHESIS
`define MWIS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("mwis assertion failed");
`define MWIS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("mwis assertion failed");
`else
`define MWIS_ASSERT_IMPL(lbl, ante, cons)
`define MWIS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/mwis_pkg.sv
// shared widths, codes and transaction structs for the subsequence engine
// no dependencies
package mwis_pkg;

	localparam int VALUE_W     = 48;
	localparam int HEIGHT_W    = 11;
	localparam int WEIGHT_W    = 32;
	localparam int CFG_W       = 11;
	localparam int LEAF_W_MAX  = 16;
	localparam int COUNT_W_MAX = 17;
	localparam int EPOCH_W     = 8;

	localparam logic [VALUE_W-1:0] VALUE_MAX  = 48'hFFFF_FFFF_FFFF;
	localparam logic [CFG_W-1:0]   CFG_RESET  = 11'd1024;

	typedef logic [VALUE_W-1:0] value_t;

	typedef enum logic {
		STATUS_OK     = 1'b0,
		STATUS_REJECT = 1'b1
	} status_t;

	typedef struct packed {
		logic                   start;
		logic                   rej;
		logic [LEAF_W_MAX-1:0]  leaf;
		logic [WEIGHT_W-1:0]    weight;
		logic [COUNT_W_MAX-1:0] eff;
	} item_t;

	typedef struct packed {
		value_t  chain;
		value_t  best;
		status_t status;
	} result_t;

endpackage

### rtl/mwis_front.sv
// front end: accepts input transactions, checks the height, queues them
// depends on mwis_pkg and the assertion macro header
`include "max_weight_increasing_subsequence_macros.svh"
module mwis_front #(
	parameter int HEIGHT_LIMIT = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [47:0]                  s_tdata,
	input  logic [0:0]                   s_tuser,
	input  logic [mwis_pkg::CFG_W-1:0]   active_heights,
	input  logic                         hold,
	input  logic                         pop,
	output logic                         item_valid,
	output mwis_pkg::item_t              item
);

	localparam int LVL = $clog2(HEIGHT_LIMIT);
	localparam int NW  = LVL + 1;

	logic [mwis_pkg::HEIGHT_W-1:0] height;
	logic [mwis_pkg::HEIGHT_W-1:0] height_m1;
	logic [NW-1:0]                 eff;
	logic                          rej;
	logic                          push;
	mwis_pkg::item_t               item_in;

	mwis_pkg::item_t q_q [2];
	logic            wr_q;
	logic            rd_q;
	logic [1:0]      cnt_q;

	assign height    = s_tdata[10:0];
	assign height_m1 = height - 11'd1;

	always_comb begin
		if (32'(active_heights) > 32'(HEIGHT_LIMIT)) begin
			eff = NW'(HEIGHT_LIMIT);
		end else begin
			eff = NW'(active_heights);
		end
		rej = (height == '0) || (32'(height) > 32'(eff));
		item_in.start  = s_tuser[0];
		item_in.rej    = rej;
		item_in.leaf   = rej ? '0 : mwis_pkg::LEAF_W_MAX'(height_m1);
		item_in.weight = s_tdata[42:11];
		item_in.eff    = mwis_pkg::COUNT_W_MAX'(eff);
	end

	assign s_tready   = (cnt_q != 2'd2) && !hold;
	assign push       = s_tvalid && s_tready;
	assign item_valid = (cnt_q != 2'd0);
	assign item       = q_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				q_q[wr_q] <= item_in;
				wr_q      <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`MWIS_ASSERT_IMPL(a_queue_bound, 1'b1, cnt_q != 2'd3)
	`MWIS_ASSERT_IMPL(a_pop_nonempty, pop, cnt_q != 2'd0)

endmodule

### rtl/mwis_engine.sv
// back end: max segment tree in one node memory, query, update and best walk
// depends on mwis_pkg and the assertion macro header
`include "max_weight_increasing_subsequence_macros.svh"
module mwis_engine #(
	parameter int HEIGHT_LIMIT = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  mwis_pkg::item_t   item,
	output logic              pop,
	output logic              clearing,
	output logic              out_valid,
	input  logic              out_ready,
	output mwis_pkg::result_t result
);

	localparam int LVL   = $clog2(HEIGHT_LIMIT);
	localparam int AW    = LVL + 1;
	localparam int NODES = 2 << LVL;
	localparam int LW    = $clog2(LVL + 1);
	localparam int DW    = mwis_pkg::EPOCH_W + mwis_pkg::VALUE_W;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_QRY, ST_ADD0, ST_ADD1, ST_UPD, ST_FIN, ST_OUT
	} state_t;

	typedef enum logic {
		RD_QUERY,
		RD_BEST
	} rd_kind_t;

	logic [DW-1:0] mem [NODES];
	logic [DW-1:0] rdata_q;

	state_t                       state_q;
	logic [LW-1:0]                lvl_q;
	logic [AW-1:0]                clr_q;
	logic [mwis_pkg::EPOCH_W-1:0] epoch_q;
	logic                         item_act_q;
	logic [LVL-1:0]               cur_leaf_q;
	logic [mwis_pkg::WEIGHT_W-1:0] cur_weight_q;
	logic [AW-1:0]                cur_eff_q;
	logic                         cur_rej_q;
	mwis_pkg::value_t             acc_q;
	mwis_pkg::value_t             best_q;
	mwis_pkg::value_t             chain_q;
	mwis_pkg::value_t             v_q;
	mwis_pkg::value_t             sib_q [LVL+1];
	logic                         rd_v_q;
	rd_kind_t                     rd_kind_q;
	logic [LW-1:0]                rd_lvl_q;
	logic                         rd_use_q;
	logic                         fwd_v_q;
	mwis_pkg::value_t             fwd_data_q;
	logic                         out_v_q;
	mwis_pkg::result_t            out_q;

	logic                         mem_we;
	logic [AW-1:0]                mem_waddr;
	logic [DW-1:0]                mem_wdata;
	logic                         mem_re;
	logic [AW-1:0]                mem_raddr;
	rd_kind_t                     rd_kind;
	logic                         rd_use;
	logic [AW-1:0]                p_path;
	logic [AW-1:0]                e_path;
	mwis_pkg::value_t             rd_val;
	logic [mwis_pkg::VALUE_W:0]   sum;
	mwis_pkg::value_t             chain_sat;
	mwis_pkg::value_t             sib_cur;

	assign p_path  = {1'b1, cur_leaf_q};
	assign e_path  = {1'b1, cur_eff_q[LVL-1:0]};
	assign sib_cur = sib_q[lvl_q];

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		rd_kind   = RD_QUERY;
		rd_use    = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_QRY: begin
				// sibling on the leaf path, left siblings feed the prefix max
				mem_re    = 1'b1;
				mem_raddr = (p_path >> lvl_q) ^ AW'(1);
				rd_kind   = RD_QUERY;
				rd_use    = p_path[lvl_q];
			end
			ST_UPD: begin
				mem_we    = !cur_rej_q;
				mem_waddr = p_path >> lvl_q;
				mem_wdata = {epoch_q, v_q};
				if (cur_eff_q[lvl_q]) begin
					mem_re  = 1'b1;
					rd_kind = RD_BEST;
					rd_use  = 1'b1;
					if (lvl_q == LW'(LVL)) begin
						mem_raddr = AW'(1);
					end else begin
						mem_raddr = (e_path >> lvl_q) - AW'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (fwd_v_q) begin
			rd_val = fwd_data_q;
		end else if (rdata_q[DW-1 -: mwis_pkg::EPOCH_W] == epoch_q) begin
			rd_val = rdata_q[mwis_pkg::VALUE_W-1:0];
		end else begin
			rd_val = '0;
		end
		sum       = {1'b0, acc_q} + (mwis_pkg::VALUE_W + 1)'(cur_weight_q);
		chain_sat = sum[mwis_pkg::VALUE_W] ? mwis_pkg::VALUE_MAX : sum[mwis_pkg::VALUE_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			lvl_q      <= '0;
			clr_q      <= '0;
			epoch_q    <= '0;
			item_act_q <= 1'b0;
			rd_v_q     <= 1'b0;
			fwd_v_q    <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			rd_v_q     <= mem_re;
			rd_kind_q  <= rd_kind;
			rd_lvl_q   <= lvl_q;
			rd_use_q   <= rd_use;
			fwd_v_q    <= mem_we && mem_re && (mem_waddr == mem_raddr);
			fwd_data_q <= v_q;
			if (rd_v_q) begin
				if (rd_kind_q == RD_QUERY) begin
					sib_q[rd_lvl_q] <= rd_val;
					if (rd_use_q && (rd_val > acc_q)) begin
						acc_q <= rd_val;
					end
				end else if (rd_val > best_q) begin
					best_q <= rd_val;
				end
			end
			if (out_v_q && out_ready && (state_q != ST_OUT)) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					lvl_q <= '0;
					if (&clr_q) begin
						epoch_q <= '0;
						if (!item_act_q) begin
							state_q <= ST_IDLE;
						end else if (cur_rej_q) begin
							state_q <= ST_UPD;
						end else begin
							state_q <= ST_QRY;
						end
					end
				end
				ST_IDLE: begin
					if (item_valid) begin
						item_act_q   <= 1'b1;
						cur_leaf_q   <= item.leaf[LVL-1:0];
						cur_weight_q <= item.weight;
						cur_eff_q    <= item.eff[AW-1:0];
						cur_rej_q    <= item.rej;
						acc_q        <= '0;
						best_q       <= '0;
						chain_q      <= '0;
						sib_q[LVL]   <= '0;
						lvl_q        <= '0;
						clr_q        <= '0;
						if (item.start && (&epoch_q)) begin
							state_q <= ST_CLEAR;
						end else begin
							if (item.start) begin
								epoch_q <= epoch_q + 1'b1;
							end
							state_q <= item.rej ? ST_UPD : ST_QRY;
						end
					end
				end
				ST_QRY: begin
					if (lvl_q == LW'(LVL - 1)) begin
						lvl_q   <= '0;
						state_q <= ST_ADD0;
					end else begin
						lvl_q <= lvl_q + LW'(1);
					end
				end
				ST_ADD0: begin
					state_q <= ST_ADD1;
				end
				ST_ADD1: begin
					chain_q <= chain_sat;
					v_q     <= chain_sat;
					lvl_q   <= '0;
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (!cur_rej_q && (sib_cur > v_q)) begin
						v_q <= sib_cur;
					end
					if (lvl_q == LW'(LVL)) begin
						state_q <= ST_FIN;
					end else begin
						lvl_q <= lvl_q + LW'(1);
					end
				end
				ST_FIN: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_v_q || out_ready) begin
						out_v_q      <= 1'b1;
						out_q.chain  <= chain_q;
						out_q.best   <= best_q;
						out_q.status <= cur_rej_q ? mwis_pkg::STATUS_REJECT : mwis_pkg::STATUS_OK;
						item_act_q   <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign pop       = (state_q == ST_IDLE) && item_valid;
	assign clearing  = (state_q == ST_CLEAR);
	assign out_valid = out_v_q;
	assign result    = out_q;

	`MWIS_ASSERT_IMPL(a_idle_no_write, state_q == ST_IDLE, !mem_we)
	`MWIS_ASSERT_IMPL(a_rej_no_write, mem_we && (state_q == ST_UPD), !cur_rej_q)
	`MWIS_ASSERT_IMPL(a_out_no_pending, state_q == ST_OUT, !rd_v_q)
	`MWIS_ASSERT_NEXT(a_clear_epoch, (state_q == ST_CLEAR) && (&clr_q), epoch_q == '0)

endmodule

### rtl/max_weight_increasing_subsequence.sv
// top level: config register, front queue and tree engine
// depends on mwis_pkg, mwis_front, mwis_engine
//
// channel  dir  tdata (low bit up)                 tuser
// s_*      in   height[10:0] weight[42:11] pad      start_new
// m_*      out  chain_value[47:0] best_so_far[95:48] status
// cfg_*    in   active_heights, written when cfg_we is high
//
// one tree level per cycle through the single node memory read port, L = log2 leaves
// accepted height: query walk, add, then update and best walk; rejected height: update and best walk only, no write
// reset starts a clearing pass over all 2*2^L node memory entries (2048) with s_tready low
// every 256th start_new repeats that clearing pass before the transaction runs
// a two-entry queue takes new transactions while the engine runs or m_tready is low
module max_weight_increasing_subsequence #(
	parameter int HEIGHT_LIMIT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // height, weight, zero pad
	input  logic [0:0]  s_tuser,   // start_new
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // chain_value, best_so_far
	output logic [0:0]  m_tuser,   // status
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata
);

	logic [mwis_pkg::CFG_W-1:0] active_heights_q;
	logic                       item_valid;
	mwis_pkg::item_t            item;
	logic                       pop;
	logic                       clearing;
	mwis_pkg::result_t          result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_heights_q <= mwis_pkg::CFG_RESET;
		end else if (cfg_we) begin
			active_heights_q <= cfg_wdata;
		end
	end

	mwis_front #(
		.HEIGHT_LIMIT(HEIGHT_LIMIT)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.active_heights(active_heights_q),
		.hold          (clearing),
		.pop           (pop),
		.item_valid    (item_valid),
		.item          (item)
	);

	mwis_engine #(
		.HEIGHT_LIMIT(HEIGHT_LIMIT)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item      (item),
		.pop       (pop),
		.clearing  (clearing),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.result    (result)
	);

	assign m_tdata = {result.best, result.chain};
	assign m_tuser = result.status;

endmodule
